// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [15:0] prio;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- rtl/core/spq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for the command words and the result words.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] item_value;
    logic        [15:0] item_priority;

    modport source (output valid, output func, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input func, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic        [1:0]  status;
    logic        [4:0]  occupancy;

    modport source (output valid, output popped_value, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input occupancy, output ready);
endinterface

// ----- rtl/core/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Fixed-capacity priority queue held as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries command words: func selects insert or pop; item_value and
//   item_priority give the entry to insert (lower priority served first,
//   equal priorities leave first in, first out).
//   o_out carries one result word per command: popped value, status
//   (ok, underflow on empty pop, overflow on full insert) and occupancy.
//   The result word is registered and appears in the cycle after
//   acceptance. One command is taken every cycle while results are taken:
//   every cell compares its priority with the new entry in parallel and
//   the whole chain shifts by one slot at once. The result register parts
//   the two sides; while it holds a word that is not taken, i_in.ready
//   drops and the chain holds. Reset clears the entry count and the result
//   valid flag, not the payload; cell contents are not cleared, as slots at or beyond the count are never read.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    logic signed [31:0]     r_popped;
    logic signed [31:0]     n_popped;
    t_status                r_status;
    t_status                n_status;
    logic [OCC_W-1:0]       r_occ;
    logic [CNT_W+OCC_W-1:0] w_count_ext;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;
    t_entry    w_new;

    logic   w_before [CAPACITY];
    t_entry w_entry  [CAPACITY];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_new.value = i_in.item_value;
    assign w_new.prio  = i_in.item_priority;

    always_comb begin
        w_ctl.insert = w_accept && (i_in.func == FUNC_INSERT) && !w_full;
        w_ctl.pop    = w_accept && (i_in.func == FUNC_POP) && !w_empty;
        n_count      = r_count;
        n_popped     = '0;
        n_status     = ST_OK;
        if (i_in.func == FUNC_INSERT) begin
            if (w_full) begin
                n_status = ST_OVERFLOW;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_popped = w_entry[0].value;
                n_count  = r_count - 1'b1;
            end
        end
    end

    assign w_count_ext = {{OCC_W{1'b0}}, n_count};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic   w_prev_before;
            t_entry w_left;
            t_entry w_right;

            if (g == 0) begin : g_head
                assign w_prev_before = 1'b0;
                assign w_left        = w_new;
            end else begin : g_body
                assign w_prev_before = w_before[g-1];
                assign w_left        = w_entry[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = w_entry[g];
            end else begin : g_mid
                assign w_right = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occupied    (r_count > CNT_W'(g)),
                .i_prev_before (w_prev_before),
                .i_new         (w_new),
                .i_left        (w_left),
                .i_right       (w_right),
                .o_before      (w_before[g]),
                .o_entry       (w_entry[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= n_popped;
            r_status <= n_status;
            r_occ    <= w_count_ext[OCC_W-1:0];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_popped;
    assign o_out.status       = r_status;
    assign o_out.occupancy    = r_occ;

endmodule

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the new
// entry and takes its left or right neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  logic      i_prev_before,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  t_entry    i_right,
    output logic      o_before,
    output t_entry    o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // new entry belongs at or before this slot
    assign o_before = !i_occupied || (r_entry.prio > i_new.prio);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (i_prev_before) begin
                n_entry = i_left;
            end else if (o_before) begin
                n_entry = i_new;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- verif/tb_sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_top
// Drives insert and pop words into the sorted priority queue and checks every
// result word against a behavioral copy of the queue kept in the bench.
// Both sides idle and stall at random; one phase holds the result side off
// long enough to back the command side up, and another drains between bursts.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_top;
    import spq_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        t_status            status;
        logic        [4:0]  occupancy;
    } t_queue_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spq_in_if  in_bus ();
    spq_out_if out_bus ();

    sorted_priority_queue_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    always #1 i_clk = ~i_clk;

    // Bench copy of the queue contents, head in slot 0
    logic signed [31:0] held_value [CAPACITY];
    logic        [15:0] held_prio  [CAPACITY];
    int                 held_count;

    t_queue_result pending_results[$];
    int            fail_count     = 0;
    int            mismatch_count = 0;
    bit            idle_en        = 1'b1;
    int            hold_req       = 0;

    function automatic t_queue_result predict_queue_op(input logic func,
                                                       input logic signed [31:0] value,
                                                       input logic [15:0] prio);
        t_queue_result res;
        int            pos;
        res.value  = '0;
        res.status = ST_OK;
        if (func == FUNC_INSERT) begin
            if (held_count >= CAPACITY) begin
                res.status = ST_OVERFLOW;
            end else begin
                // land after every entry of lower or equal priority
                pos = 0;
                while (pos < held_count && held_prio[pos] <= prio) pos++;
                for (int k = held_count; k > pos; k--) begin
                    held_value[k] = held_value[k - 1];
                    held_prio[k]  = held_prio[k - 1];
                end
                held_value[pos] = value;
                held_prio[pos]  = prio;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.value = held_value[0];
                for (int k = 1; k < held_count; k++) begin
                    held_value[k - 1] = held_value[k];
                    held_prio[k - 1]  = held_prio[k];
                end
                held_count--;
            end
        end
        res.occupancy = held_count[4:0];
        return res;
    endfunction

    // Predict on accepted commands first, then check accepted results
    always @(posedge i_clk) begin
        t_queue_result exp_res;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready)
                pending_results.push_back(predict_queue_op(in_bus.func, in_bus.item_value,
                                                           in_bus.item_priority));
            if (out_bus.valid && out_bus.ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word: value %0d status %0d occ %0d",
                                 out_bus.popped_value, out_bus.status, out_bus.occupancy);
                end else begin
                    exp_res = pending_results.pop_front();
                    if (out_bus.popped_value !== exp_res.value
                        || out_bus.status !== exp_res.status
                        || out_bus.occupancy !== exp_res.occupancy) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp value %0d status %0d occ %0d,",
                                      " got value %0d status %0d occ %0d"},
                                     exp_res.value, exp_res.status, exp_res.occupancy,
                                     out_bus.popped_value, out_bus.status, out_bus.occupancy);
                    end
                end
            end
        end
    end

    // Result side: random stall per word, plus long hold-offs on request
    initial begin
        int stall;
        int hold_len;
        out_bus.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req > 0) begin
                hold_len = hold_req;
                hold_req = 0;
                repeat (hold_len) begin
                    @(negedge i_clk);
                    out_bus.ready <= 1'b0;
                end
            end
            stall = idle_en ? $urandom_range(0, 8) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                out_bus.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_bus.ready <= 1'b1;
            do @(posedge i_clk);
            while (!(out_bus.valid && out_bus.ready) && hold_req == 0);
        end
    end

    task automatic send_word(input logic func, input logic signed [31:0] value,
                             input logic [15:0] prio);
        int gap;
        gap = idle_en ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid         <= 1'b1;
        in_bus.func          <= func;
        in_bus.item_value    <= value;
        in_bus.item_priority <= prio;
        do @(posedge i_clk);
        while (!in_bus.ready);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_prio(input bit narrow);
        int pick;
        if (narrow) return 16'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic signed [31:0] rand_value();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 32'sh8000_0000;
        if (pick == 1) return 32'sh7FFF_FFFF;
        return 32'($urandom);
    endfunction

    // Random command word; fields still toggle on pops though they are ignored
    task automatic send_random(input int insert_pct, input bit narrow);
        logic func;
        func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_POP;
        send_word(func, rand_value(), rand_prio(narrow));
    endtask

    task automatic test_directed();
        send_word(FUNC_POP, 32'sd0, 16'd0);                     // pop on empty
        send_word(FUNC_INSERT, 32'sh8000_0000, 16'hFFFF);
        send_word(FUNC_INSERT, 32'sh7FFF_FFFF, 16'h0000);
        send_word(FUNC_INSERT, -32'sd1, 16'h0000);              // tie with head
        send_word(FUNC_INSERT, 32'sd0, 16'h8000);
        send_word(FUNC_INSERT, 32'sd1, 16'hFFFF);               // tie with tail
        repeat (5) send_word(FUNC_POP, 32'sh5555_AAAA, 16'hA5A5);
        send_word(FUNC_POP, -32'sd1, 16'hFFFF);                 // empty again
        wait_drain();
    endtask

    // Fill past capacity for overflow, then pop past empty for underflow
    task automatic test_fill_overflow();
        for (int round = 0; round < 3; round++) begin
            repeat (CAPACITY + 2) send_word(FUNC_INSERT, rand_value(), rand_prio(round == 0));
            repeat (CAPACITY + 2) send_word(FUNC_POP, rand_value(), rand_prio(1'b0));
        end
    endtask

    task automatic test_random_mix(input int count, input int insert_pct);
        repeat (count) send_random(insert_pct, 1'($urandom_range(0, 1)));
    endtask

    // Hold the result side off while commands keep coming, so input stalls
    task automatic test_backpressure();
        wait_drain();
        hold_req = 80;
        idle_en  = 1'b0;
        repeat (40) send_random(60, 1'b1);
        idle_en  = 1'b1;
        wait_drain();
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        test_random_mix(150, 65);
        test_random_mix(150, 35);
        idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            repeat (20) send_random(55, 1'b0);
            wait_drain();
        end
    endtask

    initial begin
        held_count           = 0;
        in_bus.valid         = 1'b0;
        in_bus.func          = FUNC_INSERT;
        in_bus.item_value    = '0;
        in_bus.item_priority = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_overflow();
        test_random_mix(400, 70);
        test_random_mix(400, 50);
        test_random_mix(400, 30);
        test_backpressure();
        test_no_idle();
        test_drain_pause();
        wait_drain();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
verif/tb_sorted_priority_queue_top.sv
